[sv/palist_pkg.sv]
// Shared types and codes for the positional array list engine.
// No dependencies; every other file of the block refers to this package by scoped names.

package palist_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned STEP_W   = 9;
  localparam int unsigned CNT_W    = 9;

  localparam logic [STEP_W-1:0] STEP_RESET = 9'd16;

  // Register indexes on the configuration port.
  localparam logic REG_GROWTH_STEP = 1'b0;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_READ   = 3'd2,
    REQ_WRITE  = 3'd3,
    REQ_SEARCH = 3'd4
  } req_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_code_t;

endpackage

[sv/palist_if.sv]
// Valid/ready stream interfaces for the request and result channels.
// Depends on palist_pkg for field widths.

interface palist_req_if;
  logic                               valid;
  logic                               ready;
  logic [palist_pkg::REQ_W-1:0]       req_type;
  logic [palist_pkg::POS_W-1:0]       position;
  logic signed [palist_pkg::DATA_W-1:0] item_value;

  modport source (output valid, req_type, position, item_value, input ready);
  modport sink   (input valid, req_type, position, item_value, output ready);
endinterface

interface palist_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [palist_pkg::STATUS_W-1:0]      status;
  logic signed [palist_pkg::DATA_W-1:0] read_value;
  logic signed [palist_pkg::POS_W-1:0]  found_index;
  logic [palist_pkg::CNT_W-1:0]         entry_count;
  logic [palist_pkg::CNT_W-1:0]         capacity_now;

  modport source (output valid, status, read_value, found_index, entry_count, capacity_now,
                  input ready);
  modport sink   (input valid, status, read_value, found_index, entry_count, capacity_now,
                  output ready);
endinterface

[sv/palist_cell.sv]
// One storage cell of the list chain: holds one entry and loads its neighbor's value on shift.
// Depends on palist_pkg for the data width.

module palist_cell (
  input  logic                              clk,
  input  logic                              shift,
  input  logic [palist_pkg::DATA_W-1:0]     din,
  output logic [palist_pkg::DATA_W-1:0]     q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= din;
    end
  end

endmodule

[sv/palist_chain.sv]
// Row of list cells that moves toward cell 0 on every shift, fed at the far end.
// Depends on palist_pkg and palist_cell.

module palist_chain #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              shift,
  input  logic [palist_pkg::DATA_W-1:0]     feed,
  output logic [palist_pkg::DATA_W-1:0]     head,
  output logic [palist_pkg::DATA_W-1:0]     second
);

  logic [palist_pkg::DATA_W-1:0] q [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [palist_pkg::DATA_W-1:0] din;
    if (k == DEPTH - 1) begin : g_last
      assign din = feed;
    end else begin : g_mid
      assign din = q[k+1];
    end
    palist_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .din   (din),
      .q     (q[k])
    );
  end

  assign head   = q[0];
  assign second = q[1];

endmodule

[sv/positional_array_list_engine.sv]
// Top level of the positional array list engine: control, capacity bookkeeping, APB register.
// Depends on palist_pkg, palist_if, palist_chain and palist_cell.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------------------
//   req      | in        | valid/ready        | req_type, position, item_value
//   rsp      | out       | valid/ready        | status, read_value, found_index, counts
//   apb      | in        | psel/penable/pready| growth_step at byte address 0
//
// Insert, delete, read, write and search each take one full rotation of the cell chain
// before the result is formed. A request rejected for its position or a full store, and
// an unknown request, skips the rotation. The chain itself sets this: every entry passes
// cell 0 once per rotation. A new request is taken once the previous one has moved into
// the result register, even while that result still waits. Reset clears count, capacity
// and the handshake state; the list entries are not cleared.

module positional_array_list_engine #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  palist_req_if.sink                 req,
  palist_rsp_if.source               rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned W  = (CW > palist_pkg::POS_W) ? CW : palist_pkg::POS_W;
  localparam int unsigned DW = palist_pkg::DATA_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_t;

  state_t state;

  // Configuration register.
  logic [palist_pkg::STEP_W-1:0] growth_step;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      growth_step <= palist_pkg::STEP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == palist_pkg::REG_GROWTH_STEP)
    begin
      growth_step <= pwdata[palist_pkg::STEP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == palist_pkg::REG_GROWTH_STEP) begin
      prdata = 32'(growth_step);
    end
  end

  // List bookkeeping and per-request working registers.
  logic [W-1:0]                      count;
  logic [W-1:0]                      capacity;
  logic [IW-1:0]                     idx;
  logic [palist_pkg::REQ_W-1:0]      op_req;
  logic [W-1:0]                      op_pos;
  logic [W-1:0]                      op_cnt;
  logic [DW-1:0]                     op_val;
  logic [DW-1:0]                     dly;
  logic                              hit;
  logic [palist_pkg::STATUS_W-1:0]   res_status;
  logic [DW-1:0]                     res_read;
  logic [palist_pkg::POS_W-1:0]      res_found;

  logic [DW-1:0] head;
  logic [DW-1:0] second;
  logic [DW-1:0] feed;
  logic          shift;

  assign shift = (state == S_RUN);

  palist_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk    (clk),
    .shift  (shift),
    .feed   (feed),
    .head   (head),
    .second (second)
  );

  logic [W-1:0] idx_w;
  assign idx_w = W'(idx);

  // Entry that lands at list index idx after the rotation.
  always_comb begin
    feed = head;
    case (op_req)
      palist_pkg::REQ_INSERT: begin
        if (idx_w == op_pos) begin
          feed = op_val;
        end else if (idx_w > op_pos) begin
          feed = dly;
        end
      end
      palist_pkg::REQ_DELETE: begin
        if (idx_w >= op_pos) begin
          feed = second;
        end
      end
      palist_pkg::REQ_WRITE: begin
        if (idx_w == op_pos) begin
          feed = op_val;
        end
      end
      default: begin
        feed = head;
      end
    endcase
  end

  // Decision made at the request transfer.
  logic                            in_xfer;
  logic [W-1:0]                    pos_w;
  logic [palist_pkg::STEP_W-1:0]   step_eff;
  logic [W+1:0]                    grown;
  logic [W+1:0]                    shrink_need;
  logic [W-1:0]                    cap_grown;
  logic                            run_op;
  logic [palist_pkg::STATUS_W-1:0] imm_status;
  logic [W-1:0]                    count_next;
  logic [W-1:0]                    capacity_next;

  assign in_xfer   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign pos_w     = W'(req.position);
  assign step_eff  = (growth_step == '0) ? palist_pkg::STEP_W'(1) : growth_step;
  assign grown       = (W+2)'(capacity) + (W+2)'(step_eff);
  assign shrink_need = (W+2)'(count) + ((W+2)'(step_eff) << 1);
  assign cap_grown   = (grown > (W+2)'(DEPTH)) ? W'(DEPTH) : W'(grown);

  always_comb begin
    run_op        = 1'b0;
    imm_status    = palist_pkg::ST_OK;
    count_next    = count;
    capacity_next = capacity;
    case (req.req_type)
      palist_pkg::REQ_INSERT: begin
        if (pos_w > count) begin
          imm_status = palist_pkg::ST_RANGE;
        end else if (count >= W'(DEPTH)) begin
          imm_status = palist_pkg::ST_FULL;
        end else begin
          run_op     = 1'b1;
          count_next = count + W'(1);
          if (count >= capacity) begin
            capacity_next = cap_grown;
          end
        end
      end
      palist_pkg::REQ_DELETE: begin
        if (pos_w >= count) begin
          imm_status = palist_pkg::ST_RANGE;
        end else begin
          run_op     = 1'b1;
          count_next = count - W'(1);
          if (shrink_need <= (W+2)'(capacity)) begin
            capacity_next = capacity - W'(step_eff);
          end
        end
      end
      palist_pkg::REQ_READ, palist_pkg::REQ_WRITE: begin
        if (pos_w >= count) begin
          imm_status = palist_pkg::ST_RANGE;
        end else begin
          run_op = 1'b1;
        end
      end
      palist_pkg::REQ_SEARCH: begin
        run_op = 1'b1;
      end
      default: begin
        run_op = 1'b0;
      end
    endcase
  end

  logic out_free;
  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      capacity  <= '0;
      rsp.valid <= 1'b0;
      idx       <= '0;
    end else begin
      // In S_FIN a result that leaves is replaced by the next one below.
      if (rsp.valid && rsp.ready && state != S_FIN) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            count      <= count_next;
            capacity   <= capacity_next;
            op_req     <= req.req_type;
            op_pos     <= pos_w;
            op_cnt     <= count;
            op_val     <= req.item_value;
            idx        <= '0;
            hit        <= 1'b0;
            res_status <= imm_status;
            res_read   <= '0;
            res_found  <= '1;
            state      <= run_op ? S_RUN : S_FIN;
          end
        end
        S_RUN: begin
          dly <= head;
          if (op_req == palist_pkg::REQ_READ && idx_w == op_pos) begin
            res_read <= head;
          end
          // The first match below the old count wins.
          if (op_req == palist_pkg::REQ_SEARCH && !hit && idx_w < op_cnt && head == op_val)
          begin
            hit       <= 1'b1;
            res_found <= palist_pkg::POS_W'(idx_w);
          end
          if (idx == IW'(DEPTH - 1)) begin
            state <= S_FIN;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= res_status;
            rsp.read_value   <= res_read;
            rsp.found_index  <= res_found;
            rsp.entry_count  <= palist_pkg::CNT_W'(count);
            rsp.capacity_now <= palist_pkg::CNT_W'(capacity);
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/palist_list_monitor.sv]
// Watches the request, result and register ports of the positional array list engine,
// predicts each result from its own copy of the list and compares field by field.
// Depends on palist_pkg and the channel interfaces in palist_if.

module palist_list_monitor #(
  parameter int unsigned DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  palist_req_if       req,
  palist_rsp_if       rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int unsigned failures,
  output int unsigned outstanding
);

  localparam logic [2:0] GROWTH_STEP_ADDR = {palist_pkg::REG_GROWTH_STEP, 2'b00};

  typedef struct {
    palist_pkg::status_code_t                  status;
    logic signed [palist_pkg::DATA_W-1:0]      read_value;
    logic signed [palist_pkg::POS_W-1:0]       found_index;
    logic        [palist_pkg::CNT_W-1:0]       entry_count;
    logic        [palist_pkg::CNT_W-1:0]       capacity_now;
  } list_result_t;

  list_result_t                     pending_results[$];
  logic [palist_pkg::DATA_W-1:0]    entries[DEPTH];
  int                               list_count;
  int                               list_capacity;
  logic [palist_pkg::STEP_W-1:0]    growth_step;

  task automatic report(input string what);
    if (failures < 40) $display("%0t: %s", $time, what);
    failures++;
  endtask

  // Applies one request to the shadow list and returns the result it must produce.
  function automatic list_result_t apply_request(input logic [2:0] kind,
                                                 input logic [8:0] pos,
                                                 input logic [31:0] value);
    list_result_t res;
    int p;
    int s;
    res.status      = palist_pkg::ST_OK;
    res.read_value  = '0;
    res.found_index = '1;
    p = int'(pos);
    s = (growth_step == '0) ? 1 : int'(growth_step);
    case (kind)
      palist_pkg::REQ_INSERT: begin
        // The position is checked before the full store.
        if (p > list_count) begin
          res.status = palist_pkg::ST_RANGE;
        end else if (list_count >= DEPTH) begin
          res.status = palist_pkg::ST_FULL;
        end else begin
          if (list_count >= list_capacity)
            list_capacity = (list_capacity + s > DEPTH) ? DEPTH : list_capacity + s;
          for (int i = list_count; i > p; i--) entries[i] = entries[i-1];
          entries[p] = value;
          list_count++;
        end
      end
      palist_pkg::REQ_DELETE: begin
        if (p >= list_count) begin
          res.status = palist_pkg::ST_RANGE;
        end else begin
          if (list_count + 2 * s <= list_capacity) list_capacity -= s;
          for (int i = p; i + 1 < list_count; i++) entries[i] = entries[i+1];
          list_count--;
        end
      end
      palist_pkg::REQ_READ: begin
        if (p >= list_count) res.status = palist_pkg::ST_RANGE;
        else res.read_value = entries[p];
      end
      palist_pkg::REQ_WRITE: begin
        if (p >= list_count) res.status = palist_pkg::ST_RANGE;
        else entries[p] = value;
      end
      palist_pkg::REQ_SEARCH: begin
        for (int i = 0; i < list_count; i++) begin
          if (entries[i] == value) begin
            res.found_index = 9'(i);
            break;
          end
        end
      end
      default: ;
    endcase
    res.entry_count  = 9'(list_count);
    res.capacity_now = 9'(list_capacity);
    return res;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      pending_results.delete();
      list_count    = 0;
      list_capacity = 0;
      growth_step   = palist_pkg::STEP_RESET;
      foreach (entries[i]) entries[i] = '0;
    end else begin
      // Results are taken before requests so a stray result never pairs with a new request.
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          report("result transfer with no request outstanding");
        end else begin
          want = pending_results.pop_front();
          if (rsp.status !== want.status)
            report($sformatf("status %0d, expected %0d", rsp.status, want.status));
          if (rsp.read_value !== want.read_value)
            report($sformatf("read_value %0d, expected %0d", rsp.read_value,
                             want.read_value));
          if (rsp.found_index !== want.found_index)
            report($sformatf("found_index %0d, expected %0d", rsp.found_index,
                             want.found_index));
          if (rsp.entry_count !== want.entry_count)
            report($sformatf("entry_count %0d, expected %0d", rsp.entry_count,
                             want.entry_count));
          if (rsp.capacity_now !== want.capacity_now)
            report($sformatf("capacity_now %0d, expected %0d", rsp.capacity_now,
                             want.capacity_now));
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1)
        pending_results.push_back(apply_request(req.req_type, req.position,
                                                req.item_value));
      if (psel && penable && pwrite && pready && paddr == GROWTH_STEP_ADDR)
        growth_step = pwdata[palist_pkg::STEP_W-1:0];
    end
    outstanding <= pending_results.size();
  end

endmodule

[tb/tb.sv]
// Top of the positional array list engine testbench: clock, reset, request and register
// stimulus, result back-pressure and the final verdict.
// Depends on palist_pkg, palist_if, the engine itself and palist_list_monitor.

module tb;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned ITEMS = 1250;
  localparam logic [2:0]  GROWTH_STEP_ADDR = {palist_pkg::REG_GROWTH_STEP, 2'b00};
  localparam logic [palist_pkg::REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [palist_pkg::REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned failures;
  int unsigned outstanding;
  int          list_len;
  int          requests_sent;
  int          burst_left;
  logic [31:0] value_pool[8];

  palist_req_if req_ch ();
  palist_rsp_if rsp_ch ();

  positional_array_list_engine #(.DEPTH(DEPTH)) uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  palist_list_monitor #(.DEPTH(DEPTH)) monitor (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("positional_array_list_engine: mismatch");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 60) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Mostly legal positions, with the edges and some out-of-range ones mixed in.
  function automatic logic [8:0] pick_pos(input logic [2:0] kind);
    int last_ok;
    int unsigned r;
    last_ok = (kind == palist_pkg::REQ_INSERT) ? list_len : list_len - 1;
    r = $urandom_range(0, 99);
    if (r < 10) return 9'($urandom);
    if (r < 18) return 9'(last_ok + 1);
    if (last_ok < 0 || r < 26) return '0;
    if (r < 34) return 9'(last_ok);
    return 9'($urandom_range(0, last_ok));
  endfunction

  // Result side back-pressure: ready is held high for a while, then now and then dropped.
  initial begin
    int unsigned stall;
    rsp_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      rsp_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < 10) repeat ($urandom_range(100, 600)) @(posedge clk);
      else repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Called just after the clock rises; returns just after the request transfer.
  task automatic send_req(input logic [2:0] kind, input logic [8:0] pos,
                          input logic [31:0] value);
    int unsigned gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 99) < 5) burst_left = $urandom_range(10, 30);
    end
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.position   <= pos;
    req_ch.item_value <= value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (kind == palist_pkg::REQ_INSERT && int'(pos) <= list_len && list_len < DEPTH)
      list_len++;
    else if (kind == palist_pkg::REQ_DELETE && int'(pos) < list_len)
      list_len--;
    if (kind <= palist_pkg::REQ_SEARCH) requests_sent++;
  endtask

  task automatic rand_req(input int ins_w, input int del_w);
    logic [2:0]  kind;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < ins_w) begin
      kind = palist_pkg::REQ_INSERT;
    end else if (r < ins_w + del_w) begin
      kind = palist_pkg::REQ_DELETE;
    end else if (r < 97) begin
      case ($urandom_range(0, 2))
        0:       kind = palist_pkg::REQ_READ;
        1:       kind = palist_pkg::REQ_WRITE;
        default: kind = palist_pkg::REQ_SEARCH;
      endcase
    end else begin
      kind = 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
    end
    send_req(kind, pick_pos(kind), pick_value());
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned step, input int n, input int ins_w,
                           input int del_w);
    wait_idle();
    apb_write(GROWTH_STEP_ADDR, 32'(step));
    repeat (n) rand_req(ins_w, del_w);
  endtask

  initial begin
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= '0;
    req_ch.position   <= '0;
    req_ch.item_value <= '0;
    list_len      = 0;
    requests_sent = 0;
    burst_left    = 0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h7FFF_FFFF;
    value_pool[3] = 32'h8000_0000;
    value_pool[4] = 32'h0000_0001;
    for (int i = 5; i < 8; i++) value_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty list: every positional request is out of range, search finds nothing.
    send_req(palist_pkg::REQ_READ,   9'd0, 32'd0);
    send_req(palist_pkg::REQ_DELETE, 9'd0, 32'd0);
    send_req(palist_pkg::REQ_WRITE,  9'd0, 32'd5);
    send_req(palist_pkg::REQ_SEARCH, 9'd0, 32'd0);
    send_req(palist_pkg::REQ_INSERT, 9'd1, 32'd7);
    // Build a short list with the value extremes, inserting at front, end and middle.
    send_req(palist_pkg::REQ_INSERT, 9'd0, 32'h7FFF_FFFF);
    send_req(palist_pkg::REQ_INSERT, 9'd0, 32'h8000_0000);
    send_req(palist_pkg::REQ_INSERT, 9'd2, 32'h0000_0000);
    send_req(palist_pkg::REQ_INSERT, 9'd1, 32'hFFFF_FFFF);
    send_req(palist_pkg::REQ_READ,   9'd0, 32'd0);
    send_req(palist_pkg::REQ_READ,   9'd3, 32'd0);
    send_req(palist_pkg::REQ_WRITE,  9'd3, 32'd1234);
    send_req(palist_pkg::REQ_SEARCH, 9'd0, 32'h8000_0000);
    send_req(palist_pkg::REQ_SEARCH, 9'h1FF, 32'hFFFF_FFFF);
    send_req(palist_pkg::REQ_SEARCH, 9'd0, 32'd42);
    send_req(palist_pkg::REQ_READ,   9'd4, 32'd0);
    send_req(palist_pkg::REQ_READ,   9'h1FF, 32'd0);
    send_req(palist_pkg::REQ_INSERT, 9'h1FF, 32'd9);
    send_req(REQ_UNUSED_FIRST,       9'd0, 32'd0);
    send_req(REQ_UNUSED_LAST,        9'h1FF, 32'hFFFF_FFFF);
    send_req(palist_pkg::REQ_DELETE, 9'd0, 32'd0);
    send_req(palist_pkg::REQ_DELETE, 9'd2, 32'd0);
    send_req(palist_pkg::REQ_READ,   9'd1, 32'd0);
    send_req(palist_pkg::REQ_WRITE,  9'd0, 32'hAAAA_5555);

    // A step of zero behaves as a step of one.
    run_phase(0, 150, 35, 25);
    run_phase(1, 120, 40, 20);
    run_phase(DEPTH, 120, 30, 30);

    // Fill the store completely, hit the full and range cases, then drain it to shrink.
    wait_idle();
    apb_write(GROWTH_STEP_ADDR, 32'd100);
    while (list_len < DEPTH)
      send_req(palist_pkg::REQ_INSERT, 9'($urandom_range(0, list_len)), pick_value());
    send_req(palist_pkg::REQ_INSERT, 9'd0, pick_value());
    send_req(palist_pkg::REQ_INSERT, 9'(DEPTH + 1), pick_value());
    send_req(palist_pkg::REQ_INSERT, 9'h1FF, pick_value());
    send_req(palist_pkg::REQ_READ,   9'(DEPTH - 1), 32'd0);
    send_req(palist_pkg::REQ_WRITE,  9'(DEPTH - 1), pick_value());
    send_req(palist_pkg::REQ_SEARCH, 9'd0, pick_value());
    send_req(palist_pkg::REQ_DELETE, 9'(DEPTH), 32'd0);
    while (list_len > 30) rand_req(5, 75);

    run_phase(3, 200, 35, 30);
    wait_idle();
    apb_write(GROWTH_STEP_ADDR, 32'(palist_pkg::STEP_RESET));
    while (requests_sent < ITEMS) rand_req(35, 30);

    wait_idle();
    repeat (DEPTH + 20) @(posedge clk);
    if (failures == 0) $display("positional_array_list_engine: match");
    else $display("positional_array_list_engine: mismatch");
    $finish;
  end

endmodule

[sim.f]
sv/palist_pkg.sv
sv/palist_if.sv
sv/palist_cell.sv
sv/palist_chain.sv
sv/positional_array_list_engine.sv
tb/palist_list_monitor.sv
tb/tb.sv
